[rtl/core/ecfc_pkg.sv]
// Shared types, constants and the CRC-32 byte update for the Ethernet
// CRC-32 framer and checker. No dependencies.
`default_nettype none

package ecfc_pkg;

  localparam int MAX_DATA     = 1500;
  localparam int HEADER_BYTES = 14;
  localparam int COUNT_MAX    = 2047;
  localparam int TX_CAP       = (MAX_DATA > COUNT_MAX) ? COUNT_MAX : MAX_DATA;
  localparam int RX_LIMIT     = (HEADER_BYTES + MAX_DATA + 4 > COUNT_MAX) ?
                                COUNT_MAX : (HEADER_BYTES + MAX_DATA + 4);

  localparam int CNT_W = 11;

  localparam logic [CNT_W-1:0] HdrCnt     = CNT_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] MinRxCnt   = CNT_W'(HEADER_BYTES + 4);
  localparam logic [CNT_W-1:0] CountMax   = CNT_W'(COUNT_MAX);
  localparam logic [CNT_W-1:0] TxCapCnt   = CNT_W'(TX_CAP);
  localparam logic [CNT_W-1:0] RxLimitCnt = CNT_W'(RX_LIMIT);

  localparam logic [31:0] CrcPolyRefl = 32'hEDB8_8320;
  localparam logic [31:0] CrcSeed     = 32'hFFFF_FFFF;
  localparam logic [7:0]  BcastByte   = 8'hFF;

  // Positions inside the trailer and header burst of a transmit frame.
  localparam logic [4:0] BURST_CRC0   = 5'd0;
  localparam logic [4:0] BURST_DEST0  = 5'd4;
  localparam logic [4:0] BURST_SRC0   = 5'd10;
  localparam logic [4:0] BURST_LEN_HI = 5'd16;
  localparam logic [4:0] BURST_LEN_LO = 5'd17;
  localparam logic [4:0] BURST_STATUS = 5'd18;

  typedef enum logic [1:0] {
    CFG_DIRECTION = 2'd0,
    CFG_DEST_MAC  = 2'd1,
    CFG_SRC_MAC   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CRC_ERR    = 3'd1,
    ST_BCAST_DROP = 3'd2,
    ST_TOO_SHORT  = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_e;

  typedef struct packed {
    logic        direction;
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       byte_out;
    logic [CNT_W-1:0] offset;
    logic             is_status;
    logic [2:0]       status;
    logic             end_of_run;
  } result_t;

  // Reflected CRC-32 update over one byte, least significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ecfc_cfg_regs.sv]
// Configuration register file: direction and the two MAC addresses.
// Depends on ecfc_pkg.
`default_nettype none

module ecfc_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         wr_en_i,
  input  wire logic [1:0]   wr_index_i,
  input  wire logic [47:0]  wr_data_i,
  output ecfc_pkg::cfg_t    cfg_o
);
  import ecfc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CFG_DIRECTION: cfg_d.direction = wr_data_i[0];
        CFG_DEST_MAC:  cfg_d.dest_mac  = wr_data_i;
        CFG_SRC_MAC:   cfg_d.src_mac   = wr_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/ecfc_in_reg.sv]
// Input register holding one accepted byte until the engine takes it.
// Depends on ecfc_pkg.
`default_nettype none

module ecfc_in_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire ecfc_pkg::in_item_t item_i,
  input  wire logic               consume_i,
  output logic                    valid_o,
  output ecfc_pkg::in_item_t      item_o
);
  import ecfc_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  // The register frees up in the same cycle the engine takes its word.
  assign ready_o = !valid_q || consume_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[rtl/core/ecfc_out_reg.sv]
// Output register driving the result stream.
// Depends on ecfc_pkg.
`default_nettype none

module ecfc_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire ecfc_pkg::result_t res_i,
  output logic                   load_ok_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output ecfc_pkg::result_t      res_o
);
  import ecfc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign load_ok_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_ok_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

[rtl/core/ecfc_engine.sv]
// Frame engine: CRC and byte count state, transmit burst sequencer and the
// receive status decision. Depends on ecfc_pkg.
`default_nettype none

module ecfc_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ecfc_pkg::cfg_t     cfg_i,
  input  wire logic               in_valid_i,
  input  wire ecfc_pkg::in_item_t in_item_i,
  output logic                    in_consume_o,
  input  wire logic               load_ok_i,
  output logic                    emit_o,
  output ecfc_pkg::result_t       res_o
);
  import ecfc_pkg::*;

  // Frame state.
  logic [31:0]      crc_q, crc_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0]      tail_q, tail_d;
  logic             drop_q, drop_d;
  logic             over_q, over_d;

  // Burst sequencer and the frame snapshot it reads from.
  logic             burst_q, burst_d;
  logic [4:0]       idx_q, idx_d;
  logic [31:0]      crc_fin_q, crc_fin_d;
  logic [CNT_W-1:0] snap_cnt_q, snap_cnt_d;
  logic             snap_over_q, snap_over_d;

  logic [7:0]       b;
  logic             last;
  logic             lim;
  logic [31:0]      crc_n;
  logic [CNT_W-1:0] cnt_n;
  logic [31:0]      tail_n;
  logic             drop_n;
  logic             over_n;
  logic [4:0]       last_idx;
  logic [1:0]       crc_k;
  logic [2:0]       mac_k;
  logic [11:0]      len;
  result_t          burst_res;

  assign b        = in_item_i.data_byte;
  assign last     = in_item_i.last_byte;
  assign last_idx = snap_over_q ? BURST_STATUS : BURST_LEN_LO;
  assign len      = {1'b0, snap_cnt_q} + 12'd4;

  // One trailer, header or status word selected by the burst position.
  always_comb begin
    crc_k     = idx_q[1:0];
    mac_k     = 3'(idx_q - BURST_DEST0);
    burst_res = '0;
    if (idx_q < BURST_DEST0) begin
      burst_res.byte_out = 8'(crc_fin_q >> (5'd24 - {crc_k, 3'b000}));
      burst_res.offset   = HdrCnt + snap_cnt_q + CNT_W'(crc_k);
    end else if (idx_q < BURST_SRC0) begin
      burst_res.byte_out = 8'(cfg_i.dest_mac >> (6'd40 - {mac_k, 3'b000}));
      burst_res.offset   = CNT_W'(idx_q - BURST_DEST0);
    end else if (idx_q < BURST_LEN_HI) begin
      mac_k              = 3'(idx_q - BURST_SRC0);
      burst_res.byte_out = 8'(cfg_i.src_mac >> (6'd40 - {mac_k, 3'b000}));
      burst_res.offset   = CNT_W'(idx_q - BURST_DEST0);
    end else if (idx_q == BURST_LEN_HI) begin
      burst_res.byte_out = {4'd0, len[11:8]};
      burst_res.offset   = CNT_W'(idx_q - BURST_DEST0);
    end else if (idx_q == BURST_LEN_LO) begin
      burst_res.byte_out = len[7:0];
      burst_res.offset   = CNT_W'(idx_q - BURST_DEST0);
    end else begin
      burst_res.is_status = 1'b1;
      burst_res.status    = ST_TOO_LONG;
    end
    burst_res.end_of_run = (idx_q == last_idx);
  end

  always_comb begin
    crc_d        = crc_q;
    count_d      = count_q;
    tail_d       = tail_q;
    drop_d       = drop_q;
    over_d       = over_q;
    burst_d      = burst_q;
    idx_d        = idx_q;
    crc_fin_d    = crc_fin_q;
    snap_cnt_d   = snap_cnt_q;
    snap_over_d  = snap_over_q;
    in_consume_o = 1'b0;
    emit_o       = 1'b0;
    res_o        = '0;
    crc_n        = crc_q;
    cnt_n        = count_q;
    tail_n       = tail_q;
    drop_n       = drop_q;
    over_n       = over_q;
    lim          = 1'b0;

    if (burst_q) begin
      if (load_ok_i) begin
        emit_o = 1'b1;
        res_o  = burst_res;
        if (idx_q == last_idx) begin
          burst_d = 1'b0;
        end else begin
          idx_d = idx_q + 5'd1;
        end
      end
    end else if (in_valid_i && load_ok_i) begin
      in_consume_o = 1'b1;
      if (!cfg_i.direction) begin
        // Transmit: pass the payload byte on at its frame offset, unless past the cap.
        lim = over_q || (count_q >= TxCapCnt);
        if (lim) begin
          over_n = 1'b1;
        end else begin
          crc_n            = crc_byte(crc_q, b);
          cnt_n            = count_q + CNT_W'(1);
          emit_o           = 1'b1;
          res_o.byte_out   = b;
          res_o.offset     = HdrCnt + count_q;
          res_o.end_of_run = !last;
        end
        if (last) begin
          crc_fin_d   = ~crc_n;
          snap_cnt_d  = cnt_n;
          snap_over_d = over_n;
          burst_d     = 1'b1;
          idx_d       = BURST_CRC0;
        end
      end else begin
        // Receive: strip the header and keep the last four bytes aside,
        // so the CRC covers only the body in front of them.
        lim = over_q || (count_q >= RxLimitCnt);
        if (lim) begin
          over_n = 1'b1;
        end else begin
          if (count_q == '0) begin
            drop_n = (b == BcastByte);
          end
          if (count_q >= HdrCnt) begin
            if (count_q >= MinRxCnt) begin
              crc_n = crc_byte(crc_q, tail_q[31:24]);
            end
            tail_n = {tail_q[23:0], b};
          end
          if (count_q != CountMax) begin
            cnt_n = count_q + CNT_W'(1);
          end
        end
        if (last) begin
          emit_o           = 1'b1;
          res_o.is_status  = 1'b1;
          res_o.end_of_run = 1'b1;
          if (drop_n) begin
            res_o.status = ST_BCAST_DROP;
          end else if (over_n) begin
            res_o.status = ST_TOO_LONG;
          end else if (cnt_n < MinRxCnt) begin
            res_o.status = ST_TOO_SHORT;
          end else if (~crc_n == tail_n) begin
            res_o.status = ST_OK;
          end else begin
            res_o.status = ST_CRC_ERR;
          end
        end
      end

      if (last) begin
        crc_d   = CrcSeed;
        count_d = '0;
        tail_d  = '0;
        drop_d  = 1'b0;
        over_d  = 1'b0;
      end else begin
        crc_d   = crc_n;
        count_d = cnt_n;
        tail_d  = tail_n;
        drop_d  = drop_n;
        over_d  = over_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CrcSeed;
      count_q <= '0;
      tail_q  <= '0;
      drop_q  <= 1'b0;
      over_q  <= 1'b0;
      burst_q <= 1'b0;
      idx_q   <= BURST_CRC0;
    end else begin
      crc_q   <= crc_d;
      count_q <= count_d;
      tail_q  <= tail_d;
      drop_q  <= drop_d;
      over_q  <= over_d;
      burst_q <= burst_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_fin_q   <= crc_fin_d;
    snap_cnt_q  <= snap_cnt_d;
    snap_over_q <= snap_over_d;
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> (idx_q <= BURST_STATUS))
    else $error("burst position out of range");

  a_burst_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> !in_consume_o)
    else $error("input taken during a trailer burst");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> load_ok_i)
    else $error("result produced while the output register is full");

  a_tx_last_bursts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_consume_o && !cfg_i.direction && in_item_i.last_byte) |=> burst_q)
    else $error("transmit frame end did not start the trailer burst");

  a_frame_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_consume_o && in_item_i.last_byte) |=> (count_q == '0 && !over_q))
    else $error("frame state not cleared after the last byte");

  a_status_only_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (burst_q && idx_q == BURST_STATUS) |-> snap_over_q)
    else $error("overflow status sent for a frame that fit");

endmodule

`default_nettype wire

[rtl/core/eth_frame_crc32_framer_checker.sv]
// Top level of the Ethernet CRC-32 framer and checker.
// Depends on ecfc_pkg, ecfc_cfg_regs, ecfc_in_reg, ecfc_engine, ecfc_out_reg.
//
// Usage notes.
// Bytes enter on the s_axis channel, one word per cycle while s_axis_tready
// is high, with tlast on the final byte of a payload (transmit) or of a whole
// frame (receive). Results leave on the m_axis channel; tlast marks the final
// word caused by one input byte and tuser flags an end-of-frame status word.
// Configuration goes through the cfg channel (index 0 direction, 1 destination
// MAC, 2 source MAC). cfg_ready_o is always high; write only while idle.
// A byte accepted into the input register passes through the engine into
// the output register, which presents the resulting word on m_axis.
// Throughput: one byte per cycle while the output is not stalled. In
// transmit mode the last byte is followed by an 18-word burst (four CRC
// bytes, then the 14 header bytes) plus one status word when the payload
// overflowed; the burst sequencer emits one word a cycle while the output
// has room, and holds the input register meanwhile. In receive mode bytes
// produce nothing until the last one, which yields a single status word.
// Reset clears the configuration to zero, the CRC to all ones and all frame
// counters; no word is pending after reset.
// When the receiver stalls, the output register holds its word, the engine
// stops, and s_axis_tready drops once the input register is also occupied.
`default_nettype none

module eth_frame_crc32_framer_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input byte stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] byte_out, [18:8] offset,
                                           // [21:19] status, [23:22] zero
  output logic             m_axis_tuser,   // is_status
  output logic             m_axis_tlast,   // end_of_run
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [47:0] cfg_data_i
);
  import ecfc_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     consume;
  logic     load_ok;
  logic     emit;
  result_t  res;
  result_t  out_res;

  // The register file never stalls a write.
  assign cfg_ready_o = 1'b1;

  ecfc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign in_item.data_byte = s_axis_tdata;
  assign in_item.last_byte = s_axis_tlast;

  ecfc_in_reg u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .consume_i (consume),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  ecfc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (held_valid),
    .in_item_i    (held_item),
    .in_consume_o (consume),
    .load_ok_i    (load_ok),
    .emit_o       (emit),
    .res_o        (res)
  );

  ecfc_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (emit),
    .res_i     (res),
    .load_ok_o (load_ok),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .res_o     (out_res)
  );

  assign m_axis_tdata = {2'b00, out_res.status, out_res.offset, out_res.byte_out};
  assign m_axis_tuser = out_res.is_status;
  assign m_axis_tlast = out_res.end_of_run;

endmodule

`default_nettype wire

[tb/sv/eth_frame_crc32_framer_checker_tb.sv]
// Self-checking testbench for the Ethernet CRC-32 framer and checker.
// Needs ecfc_pkg and the eth_frame_crc32_framer_checker RTL; reads no files.
// A queue-fed byte driver and a result monitor check every word against a local frame model.
module eth_frame_crc32_framer_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ecfc_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 10;
  // Idle cycles after a drain, enough for the engine to finish a transmit
  // trailer burst and for the block to settle.
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RAND_ITEMS    = 150;
  localparam int RAND_PHASES   = 6;
  localparam int LONG_HOLD     = 150;
  localparam int HOLD_SPACING  = 1500;

  localparam logic       DIR_TX        = 1'b0;
  localparam logic       DIR_RX        = 1'b1;
  // Index past the end of the register list; the block must ignore it.
  localparam logic [1:0] CFG_IDX_SPARE = 2'd3;

  // Clock and reset. Reset is held for the first cycles only.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Block ports, all inputs known from time zero.
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0; // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [7:0] byte_out, [18:8] offset, [21:19] status
  logic        m_axis_tuser;         // is_status
  logic        m_axis_tlast;         // end_of_run
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [47:0] cfg_data_i    = '0;

  eth_frame_crc32_framer_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Bytes waiting to be offered, and result words the frame model expects.
  in_item_t byte_q[$];
  result_t  exp_words[$];

  // Frame model: a copy of the register file and the per-frame state.
  cfg_t             shadow_cfg  = '0;
  logic [31:0]      crc_acc     = CrcSeed;
  logic [CNT_W-1:0] frame_len   = '0;
  logic [31:0]      tail_word   = '0;
  logic             bcast_seen  = 1'b0;
  logic             overflowed  = 1'b0;

  // Bookkeeping.
  int unsigned fail_cnt     = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_in     = 0;
  int unsigned words_out    = 0;
  int unsigned reg_writes   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned status_seen[8];
  bit          byte_taken   = 1'b0;

  // Sender and receiver pacing state.
  int          gap_left     = 0;
  int          burst_left   = 0;
  int          hold_left    = 0;
  int unsigned next_hold_at = 40;
  int          pat_left     = 0;
  logic [15:0] rdy_pattern  = '1;

  // Reflected CRC-32, one input bit per round, least significant bit first.
  function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = {1'b0, r[31:1]} ^ (fb ? CrcPolyRefl : 32'h0);
    end
    return r;
  endfunction

  function automatic void frame_restart();
    crc_acc    = CrcSeed;
    frame_len  = '0;
    tail_word  = '0;
    bcast_seen = 1'b0;
    overflowed = 1'b0;
  endfunction

  function automatic void push_word(input logic [7:0] b, input logic [CNT_W-1:0] off,
                                    input logic is_st, input status_e st, input logic eor);
    result_t w;
    w.byte_out   = b;
    w.offset     = off;
    w.is_status  = is_st;
    w.status     = st;
    w.end_of_run = eor;
    exp_words.push_back(w);
  endfunction

  // Works out the words that one accepted byte causes, under the current
  // direction, and appends them to the expectation queue.
  task automatic frame_step(input logic [7:0] b, input logic last);
    logic [31:0] fcs;
    logic [15:0] len_field;
    status_e     st;
    if (shadow_cfg.direction == DIR_TX) begin
      // Payload bytes past the cap are dropped and remembered as an overflow.
      if (overflowed || frame_len >= TxCapCnt) begin
        overflowed = 1'b1;
      end else begin
        crc_acc = crc32_update(crc_acc, b);
        push_word(b, HdrCnt + frame_len, 1'b0, ST_OK, !last);
        frame_len = frame_len + CNT_W'(1);
      end
      if (last) begin
        // Trailer first (FCS, most significant byte first), then the header.
        fcs       = ~crc_acc;
        len_field = {5'd0, frame_len} + 16'd4;
        for (int i = 0; i < 4; i++)
          push_word(fcs[31-8*i -: 8], HdrCnt + frame_len + CNT_W'(i), 1'b0, ST_OK, 1'b0);
        for (int i = 0; i < 6; i++)
          push_word(shadow_cfg.dest_mac[47-8*i -: 8], CNT_W'(i), 1'b0, ST_OK, 1'b0);
        for (int i = 0; i < 6; i++)
          push_word(shadow_cfg.src_mac[47-8*i -: 8], CNT_W'(6 + i), 1'b0, ST_OK, 1'b0);
        push_word(len_field[15:8], CNT_W'(12), 1'b0, ST_OK, 1'b0);
        push_word(len_field[7:0], CNT_W'(13), 1'b0, ST_OK, !overflowed);
        if (overflowed)
          push_word(8'h00, '0, 1'b1, ST_TOO_LONG, 1'b1);
        frame_restart();
      end
    end else begin
      // Receive: bytes past the length limit are ignored, the frame is marked long.
      if (overflowed || frame_len >= RxLimitCnt) begin
        overflowed = 1'b1;
      end else begin
        if (frame_len == '0)
          bcast_seen = (b == BcastByte);
        // The last four bytes seen sit in tail_word; a byte enters the CRC only
        // once four newer bytes have pushed it out of that window.
        if (frame_len >= HdrCnt) begin
          if (frame_len >= MinRxCnt)
            crc_acc = crc32_update(crc_acc, tail_word[31:24]);
          tail_word = {tail_word[23:0], b};
        end
        if (frame_len < CountMax)
          frame_len = frame_len + CNT_W'(1);
      end
      if (last) begin
        // Broadcast drop wins over too long, which wins over too short.
        if (bcast_seen)
          st = ST_BCAST_DROP;
        else if (overflowed)
          st = ST_TOO_LONG;
        else if (frame_len < MinRxCnt)
          st = ST_TOO_SHORT;
        else
          st = (~crc_acc == tail_word) ? ST_OK : ST_CRC_ERR;
        push_word(8'h00, '0, 1'b1, st, 1'b1);
        frame_restart();
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Stimulus helpers. They only fill the byte queue; the driver paces it.
  function automatic void push_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    byte_q.push_back(it);
    bytes_queued++;
  endfunction

  // A run of random bytes closed by last: a transmit payload, or receive noise.
  function automatic void queue_random_run(input int n);
    for (int i = 0; i < n; i++)
      push_byte(8'($urandom), i == n - 1);
  endfunction

  // A received frame: 14 header bytes, body, and a big-endian FCS of the body.
  function automatic void queue_rx_frame(input int body_len, input bit bcast, input bit corrupt);
    logic [31:0] acc;
    logic [7:0]  b;
    acc = CrcSeed;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      b = 8'($urandom);
      if (i == 0)
        b = bcast ? BcastByte : ((b == BcastByte) ? 8'h7F : b);
      push_byte(b, 1'b0);
    end
    for (int i = 0; i < body_len; i++) begin
      b   = 8'($urandom);
      acc = crc32_update(acc, b);
      push_byte(b, 1'b0);
    end
    acc = ~acc;
    if (corrupt)
      acc = acc ^ (32'h1 << $urandom_range(0, 31));
    for (int i = 0; i < 4; i++)
      push_byte(acc[31-8*i -: 8], i == 3);
  endfunction

  // Register writes. Valid stays up across back-to-back writes and is dropped
  // by reg_release, so no signal sees two updates in one time step.
  task automatic reg_write(input logic [1:0] idx, input logic [47:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_DIRECTION: shadow_cfg.direction = val[0];
      CFG_DEST_MAC:  shadow_cfg.dest_mac  = val;
      CFG_SRC_MAC:   shadow_cfg.src_mac   = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic reg_release();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input logic dir, input logic [47:0] dst, input logic [47:0] own);
    reg_write(CFG_DIRECTION, {47'd0, dir});
    reg_write(CFG_DEST_MAC, dst);
    reg_write(CFG_SRC_MAC, own);
  endtask

  // Waits until every queued byte is taken and every expected word has come,
  // then lets the block settle so a partial receive frame is fully absorbed.
  task automatic drain();
    while (byte_q.size() != 0 || exp_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Byte driver. Inputs move on the falling edge. A word on offer is held
  // until the block takes it; between words the sender alternates random
  // bursts and gaps, sometimes with no gap at all.
  always @(negedge clk_i) begin : byte_driver
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !byte_taken)) begin
      if (gap_left == 0 && burst_left == 0) begin
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
      end
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= byte_q[0].data_byte;
        s_axis_tlast  <= byte_q[0].last_byte;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    byte_taken = 1'b0;
  end

  // Result receiver. It follows a rotating ready pattern that is redrawn at
  // random intervals (sometimes always ready), and from time to time, while
  // the sender is offering bytes, it holds off for a long stretch so the
  // block's registers fill and s_axis_tready has to drop.
  always @(negedge clk_i) begin : result_sink
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (s_axis_tvalid && words_out >= next_hold_at) begin
      hold_left     = LONG_HOLD - 1;
      next_hold_at += HOLD_SPACING;
      m_axis_tready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        case ($urandom_range(0, 2))
          0:       rdy_pattern = '1;
          1:       rdy_pattern = 16'($urandom) | 16'h0001;
          default: rdy_pattern = (16'($urandom) & 16'($urandom)) | 16'h8000;
        endcase
        pat_left = $urandom_range(16, 80);
      end
      pat_left--;
      rdy_pattern = {rdy_pattern[14:0], rdy_pattern[15]};
      m_axis_tready <= rdy_pattern[0];
    end
  end

  // Monitor. On each rising edge, a byte taken by the block goes through the
  // frame model, and a word leaving the block is checked against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin : monitor
    result_t  want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        void'(byte_q.pop_front());
        byte_taken = 1'b1;
        bytes_in++;
        frame_step(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        if (exp_words.size() == 0) begin
          $error("result word with nothing expected: tdata %h tuser %b tlast %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_cnt++;
        end else begin
          want = exp_words.pop_front();
          check_field("byte_out", 32'(want.byte_out), 32'(m_axis_tdata[7:0]));
          check_field("offset", 32'(want.offset), 32'(m_axis_tdata[18:8]));
          check_field("is_status", 32'(want.is_status), 32'(m_axis_tuser));
          check_field("status", 32'(want.status), 32'(m_axis_tdata[21:19]));
          check_field("end_of_run", 32'(want.end_of_run), 32'(m_axis_tlast));
          if (want.is_status)
            status_seen[want.status]++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes unsent, %0d words outstanding",
               cycle_cnt, byte_q.size(), exp_words.size());
      $display("eth_frame_crc32_framer_checker verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          pick;
    int unsigned phase_start;
    logic        dir;
    logic [47:0] dst_mac;
    logic [47:0] own_mac;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: transmit under the reset configuration (both addresses zero),
    // a one-byte payload and a short one, together covering the extreme byte values.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b1);
    drain();

    // All-ones destination, a random source, and a write to the unused index
    // that must leave the registers alone.
    reg_write(CFG_DEST_MAC, '1);
    reg_write(CFG_SRC_MAC, {16'($urandom), $urandom});
    reg_write(CFG_IDX_SPARE, '1);
    reg_release();
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b1);
    drain();

    // Receive: a minimum-length good frame, a one-byte runt, and a one-byte
    // broadcast frame.
    set_config(DIR_RX, '0, '1);
    reg_release();
    queue_rx_frame(0, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    // Start a receive frame and switch to transmit before it ends: the frame
    // state carries over and the payload continues after the bytes counted.
    push_byte(8'($urandom), 1'b0);
    push_byte(8'($urandom), 1'b0);
    push_byte(8'($urandom), 1'b0);
    drain();
    reg_write(CFG_DIRECTION, {47'd0, DIR_TX});
    reg_release();
    push_byte(8'($urandom), 1'b0);
    push_byte(8'($urandom), 1'b1);
    drain();

    // Random phases, alternating direction, each with a fresh configuration.
    // Receive phases are mostly well-formed frames with random content, the
    // rest corrupted FCS, runts and broadcasts.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      dir     = (ph % 2 == 1) ? DIR_RX : DIR_TX;
      dst_mac = (ph == 3) ? '1 : {16'($urandom), $urandom};
      own_mac = (ph == 3) ? '1 : ((ph == 4) ? '0 : {16'($urandom), $urandom});
      set_config(dir, dst_mac, own_mac);
      if ($urandom_range(0, 1) == 1)
        reg_write(CFG_IDX_SPARE, {16'($urandom), $urandom});
      reg_release();
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < RAND_ITEMS / RAND_PHASES) begin
        if (dir == DIR_TX) begin
          queue_random_run(($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                                       : $urandom_range(1, 12));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 60)
            queue_rx_frame($urandom_range(0, 8), 1'b0, 1'b0);
          else if (pick < 80)
            queue_rx_frame($urandom_range(0, 8), 1'b0, 1'b1);
          else if (pick < 92)
            queue_random_run($urandom_range(1, 17));
          else
            queue_rx_frame($urandom_range(0, 4), 1'b1, 1'b0);
        end
      end
      drain();
    end

    $display("Run covered %0d bytes in, %0d result words checked, %0d register writes.",
             bytes_in, words_out, reg_writes);
    $display("Status words: ok %0d, crc error %0d, broadcast %0d, short %0d, long %0d.",
             status_seen[ST_OK], status_seen[ST_CRC_ERR], status_seen[ST_BCAST_DROP],
             status_seen[ST_TOO_SHORT], status_seen[ST_TOO_LONG]);
    if (fail_cnt == 0) begin
      $display("eth_frame_crc32_framer_checker verification clean");
    end else begin
      $display("eth_frame_crc32_framer_checker verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ecfc_pkg.sv
rtl/core/ecfc_cfg_regs.sv
rtl/core/ecfc_in_reg.sv
rtl/core/ecfc_out_reg.sv
rtl/core/ecfc_engine.sv
rtl/core/eth_frame_crc32_framer_checker.sv
tb/sv/eth_frame_crc32_framer_checker_tb.sv
